// ===== rtl/csr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_pkg
// Shared types and constants for the COBS stream receiver.
// ----------------------------------------------------------------------------
package csr_pkg;

	localparam int unsigned COUNTER_WIDTH_DEF = 32;
	localparam int unsigned STAT_W            = 32;
	localparam logic [15:0] MAX_FRAME_RESET   = 16'd1024;

	// counter slots
	localparam int unsigned NUM_CNT         = 6;
	localparam int unsigned CNT_DROP        = 0;
	localparam int unsigned CNT_PARITY      = 1;
	localparam int unsigned CNT_FRAMING     = 2;
	localparam int unsigned CNT_OVERFLOW    = 3;
	localparam int unsigned CNT_BREAK       = 4;
	localparam int unsigned CNT_BUFFER_FULL = 5;

	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] CODE_FULL = 8'hFF;

	typedef enum logic [2:0] {
		EV_DATA        = 3'd0,
		EV_PARITY      = 3'd1,
		EV_FRAMING     = 3'd2,
		EV_OVERFLOW    = 3'd3,
		EV_BREAK       = 3'd4,
		EV_BUFFER_FULL = 3'd5,
		EV_OTHER       = 3'd6
	} event_kind_t;

	typedef enum logic [2:0] {
		RK_NONE    = 3'd0,
		RK_BYTE    = 3'd1,
		RK_DONE    = 3'd2,
		RK_DROPPED = 3'd3,
		RK_PHYS    = 3'd4
	} result_kind_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_ZERO_CODE = 2'd1,
		ERR_SKIP      = 2'd2,
		ERR_LENGTH    = 2'd3
	} error_code_t;

	// per-word decode outcome
	typedef struct packed {
		result_kind_t kind;
		logic [7:0]   decoded_byte;
		logic [15:0]  byte_index;
		logic [15:0]  frame_length;
		error_code_t  error_code;
	} dec_result_t;

	// counter bump requests from the decoder
	typedef struct packed {
		logic drop;
	} dec_status_t;

endpackage

// ===== rtl/csr_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_ifs
// Valid/ready channels for receive events and decode results.
// ----------------------------------------------------------------------------
interface csr_event_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_kind;
	logic [7:0] data_byte;

	modport source (output valid, output event_kind, output data_byte, input ready);
	modport sink   (input valid, input event_kind, input data_byte, output ready);
endinterface

interface csr_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  result_kind;
	logic [7:0]  decoded_byte;
	logic [15:0] byte_index;
	logic [15:0] frame_length;
	logic [1:0]  error_code;
	logic [31:0] drop_total;
	logic [31:0] parity_errors;
	logic [31:0] framing_errors;
	logic [31:0] overflow_errors;
	logic [31:0] break_events;
	logic [31:0] buffer_full_events;

	modport source (
		output valid, output result_kind, output decoded_byte, output byte_index,
		output frame_length, output error_code, output drop_total,
		output parity_errors, output framing_errors, output overflow_errors,
		output break_events, output buffer_full_events, input ready
	);
	modport sink (
		input valid, input result_kind, input decoded_byte, input byte_index,
		input frame_length, input error_code, input drop_total,
		input parity_errors, input framing_errors, input overflow_errors,
		input break_events, input buffer_full_events, output ready
	);
endinterface

// ===== rtl/csr_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_decoder
// COBS framing state and per-word decode.
// ----------------------------------------------------------------------------
module csr_decoder (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  csr_pkg::event_kind_t  event_kind,
	input  logic [7:0]            data_byte,
	input  logic [15:0]           max_frame_bytes,
	output csr_pkg::dec_result_t  result,
	output csr_pkg::dec_status_t  status
);

	logic        in_sync_q, in_sync_d;
	logic        code_seen_q, code_seen_d;   // frame position nonzero
	logic [7:0]  skip_q, skip_d;
	logic        full_q, full_d;
	logic [15:0] count_q, count_d;

	logic [7:0]  skip_dec;
	logic        emit;
	logic [7:0]  val;

	always_comb begin
		in_sync_d   = in_sync_q;
		code_seen_d = code_seen_q;
		skip_d      = skip_q;
		full_d      = full_q;
		count_d     = count_q;
		result      = '{kind: csr_pkg::RK_NONE, error_code: csr_pkg::ERR_NONE, default: '0};
		status      = '{drop: 1'b0};
		skip_dec    = skip_q - 8'd1;
		emit        = 1'b0;
		val         = data_byte;

		case (event_kind)
			csr_pkg::EV_PARITY, csr_pkg::EV_FRAMING,
			csr_pkg::EV_OVERFLOW, csr_pkg::EV_BREAK: begin
				result.kind = csr_pkg::RK_PHYS;
				status.drop = 1'b1;
			end
			csr_pkg::EV_DATA: begin
				if (!in_sync_q) begin
					if (data_byte == csr_pkg::BYTE_ZERO)
						in_sync_d = 1'b1;
				end else if (!code_seen_q) begin
					if (data_byte == csr_pkg::BYTE_ZERO) begin
						result.kind       = csr_pkg::RK_DROPPED;
						result.error_code = csr_pkg::ERR_ZERO_CODE;
						status.drop       = 1'b1;
					end else begin
						skip_d      = data_byte;
						full_d      = (data_byte == csr_pkg::CODE_FULL);
						code_seen_d = 1'b1;
					end
				end else if (data_byte == csr_pkg::BYTE_ZERO) begin
					if (skip_q != 8'd1) begin
						result.kind       = csr_pkg::RK_DROPPED;
						result.error_code = csr_pkg::ERR_SKIP;
						status.drop       = 1'b1;
					end else begin
						result.kind         = csr_pkg::RK_DONE;
						result.frame_length = count_q;
						code_seen_d         = 1'b0;
						skip_d              = '0;
						full_d              = 1'b0;
						count_d             = '0;
					end
				end else begin
					if (skip_dec == 8'd0) begin
						// block boundary: this byte is the next code
						emit   = !full_q;
						val    = csr_pkg::BYTE_ZERO;
						skip_d = data_byte;
						full_d = (data_byte == csr_pkg::CODE_FULL);
					end else begin
						emit   = 1'b1;
						skip_d = skip_dec;
					end
					if (emit && (count_q >= max_frame_bytes)) begin
						result.kind       = csr_pkg::RK_DROPPED;
						result.error_code = csr_pkg::ERR_LENGTH;
						status.drop       = 1'b1;
					end else if (emit) begin
						result.kind         = csr_pkg::RK_BYTE;
						result.decoded_byte = val;
						result.byte_index   = count_q;
						count_d             = count_q + 16'd1;
					end
				end
			end
			default: begin
			end
		endcase

		if (status.drop) begin
			in_sync_d   = 1'b0;
			code_seen_d = 1'b0;
			skip_d      = '0;
			full_d      = 1'b0;
			count_d     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sync_q   <= 1'b0;
			code_seen_q <= 1'b0;
			skip_q      <= '0;
			full_q      <= 1'b0;
			count_q     <= '0;
		end else if (fire) begin
			in_sync_q   <= in_sync_d;
			code_seen_q <= code_seen_d;
			skip_q      <= skip_d;
			full_q      <= full_d;
			count_q     <= count_d;
		end
	end

endmodule

// ===== rtl/csr_counters.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_counters
// Wrapping event and drop counters; presents the post-update values.
// ----------------------------------------------------------------------------
module csr_counters #(
	parameter int unsigned COUNTER_WIDTH = csr_pkg::COUNTER_WIDTH_DEF
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           fire,
	input  csr_pkg::event_kind_t                           event_kind,
	input  csr_pkg::dec_status_t                           status,
	output logic [csr_pkg::NUM_CNT-1:0][COUNTER_WIDTH-1:0] count_next
);

	logic [csr_pkg::NUM_CNT-1:0][COUNTER_WIDTH-1:0] count_q;
	logic [csr_pkg::NUM_CNT-1:0]                    bump;

	always_comb begin
		bump = '0;
		bump[csr_pkg::CNT_DROP] = status.drop;
		case (event_kind)
			csr_pkg::EV_PARITY:      bump[csr_pkg::CNT_PARITY]      = 1'b1;
			csr_pkg::EV_FRAMING:     bump[csr_pkg::CNT_FRAMING]     = 1'b1;
			csr_pkg::EV_OVERFLOW:    bump[csr_pkg::CNT_OVERFLOW]    = 1'b1;
			csr_pkg::EV_BREAK:       bump[csr_pkg::CNT_BREAK]       = 1'b1;
			csr_pkg::EV_BUFFER_FULL: bump[csr_pkg::CNT_BUFFER_FULL] = 1'b1;
			default: begin
			end
		endcase
		for (int i = 0; i < csr_pkg::NUM_CNT; i++)
			count_next[i] = count_q[i] + {{(COUNTER_WIDTH-1){1'b0}}, bump[i]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			count_q <= count_next;
		end
	end

endmodule

// ===== rtl/cobs_stream_receiver_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cobs_stream_receiver_unit
// COBS decoder for a UART receive event stream, with error counters.
// ----------------------------------------------------------------------------
// Path: an accepted event waits in the event reg; its result is then
//   registered in the result reg, where it can be taken.
// Throughput: one word per cycle; the whole decode step sits between the
//   event register and the result register, and exactly one result word
//   leaves for each event word. A result held by res.ready low stalls the
//   event side once the event register is full as well.
// Reset (arst_n low): unsynchronized, frame state and all counters cleared,
//   both pipeline stages empty, max_frame_bytes back to 1024.
// ----------------------------------------------------------------------------
module cobs_stream_receiver_unit #(
	parameter int unsigned COUNTER_WIDTH = csr_pkg::COUNTER_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	csr_event_if.sink     evt,
	csr_result_if.source  res,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata
);

	// ---- configuration ------------------------------------------------------
	logic [15:0] max_frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_q <= csr_pkg::MAX_FRAME_RESET;
		end else if (cfg_we) begin
			max_frame_q <= cfg_wdata;
		end
	end

	// ---- stage 1: event register ----------------------------------------------
	// The stage advances whenever the result register is empty or drained in
	// the same cycle. With a result waiting, one more event can still land
	// here; after that evt.ready stays low until the result leaves.
	logic                 valid_s1;
	csr_pkg::event_kind_t kind_s1;
	logic [7:0]           byte_s1;
	logic                 valid_s2;
	logic                 advance;

	assign advance   = valid_s1 && (!valid_s2 || res.ready);
	assign evt.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.ready && evt.valid) begin
			kind_s1 <= csr_pkg::event_kind_t'(evt.event_kind);
			byte_s1 <= evt.data_byte;
		end
	end

	// ---- decode and counters (state commits on advance) -----------------------
	csr_pkg::dec_result_t dec_res;
	csr_pkg::dec_status_t dec_stat;
	logic [csr_pkg::NUM_CNT-1:0][COUNTER_WIDTH-1:0] cnt_next;
	logic [csr_pkg::NUM_CNT-1:0][csr_pkg::STAT_W-1:0] cnt_stat;

	csr_decoder u_decoder (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (advance),
		.event_kind      (kind_s1),
		.data_byte       (byte_s1),
		.max_frame_bytes (max_frame_q),
		.result          (dec_res),
		.status          (dec_stat)
	);

	csr_counters #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_counters (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (advance),
		.event_kind (kind_s1),
		.status     (dec_stat),
		.count_next (cnt_next)
	);

	// Counters are reported at 32 bits: truncated when wider, zero-filled
	// when narrower.
	generate
		if (COUNTER_WIDTH >= csr_pkg::STAT_W) begin : g_trunc
			for (genvar i = 0; i < csr_pkg::NUM_CNT; i++) begin : g_c
				assign cnt_stat[i] = cnt_next[i][csr_pkg::STAT_W-1:0];
			end
		end else begin : g_ext
			for (genvar i = 0; i < csr_pkg::NUM_CNT; i++) begin : g_c
				assign cnt_stat[i] = {{(csr_pkg::STAT_W-COUNTER_WIDTH){1'b0}}, cnt_next[i]};
			end
		end
	endgenerate

	// ---- stage 2: result register ---------------------------------------------
	csr_pkg::dec_result_t                             res_s2;
	logic [csr_pkg::NUM_CNT-1:0][csr_pkg::STAT_W-1:0] cnt_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= dec_res;
			cnt_s2 <= cnt_stat;
		end
	end

	assign res.valid              = valid_s2;
	assign res.result_kind        = res_s2.kind;
	assign res.decoded_byte       = res_s2.decoded_byte;
	assign res.byte_index         = res_s2.byte_index;
	assign res.frame_length       = res_s2.frame_length;
	assign res.error_code         = res_s2.error_code;
	assign res.drop_total         = cnt_s2[csr_pkg::CNT_DROP];
	assign res.parity_errors      = cnt_s2[csr_pkg::CNT_PARITY];
	assign res.framing_errors     = cnt_s2[csr_pkg::CNT_FRAMING];
	assign res.overflow_errors    = cnt_s2[csr_pkg::CNT_OVERFLOW];
	assign res.break_events       = cnt_s2[csr_pkg::CNT_BREAK];
	assign res.buffer_full_events = cnt_s2[csr_pkg::CNT_BUFFER_FULL];

endmodule

// ===== verif/cobs_stream_receiver_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cobs_stream_receiver_unit_tb
// Self-checking bench for the COBS stream receiver. A directed table covers
// sync, every event kind and the zero-code and skip errors; random phases
// then send COBS-encoded frames, noise, broken frames and line errors under
// several max_frame_bytes settings. Every result word is checked against an
// in-bench decoder model. Both channels idle at random.
// ----------------------------------------------------------------------------
module cobs_stream_receiver_unit_tb;
	import csr_pkg::*;

	localparam int unsigned RESET_CYCLES  = 7;
	localparam int unsigned SETTLE_CYCLES = 4;    // two-stage pipe plus margin
	localparam int unsigned IDLE_LIMIT    = 3000; // covers the long hold below
	localparam int unsigned RANDOM_WORDS  = 950;
	localparam int unsigned NUM_PHASES    = 5;
	localparam int unsigned HOLD_AT       = 400;  // input words before the long hold
	localparam int unsigned HOLD_CYCLES   = 200;
	localparam int unsigned REPORT_MAX    = 10;
	localparam int unsigned N_DIRECTED    = 24;

	// event code the package leaves unnamed; the block must ignore it
	localparam logic [2:0] EV_UNUSED = 3'd7;

	typedef logic [7:0] byte_q_t[$];

	// one result word as the block should present it
	typedef struct packed {
		result_kind_t                  kind;
		logic [7:0]                    dbyte;
		logic [15:0]                   idx;
		logic [15:0]                   flen;
		error_code_t                   err;
		logic [NUM_CNT-1:0][STAT_W-1:0] tally;
	} rx_word_t;

	// directed row; kind/error typed in only where obvious, else from the model
	typedef struct {
		logic [2:0]   kind;
		logic [7:0]   data;
		bit           typed;
		result_kind_t tkind;
		error_code_t  terr;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	csr_event_if  evt_if ();
	csr_result_if res_if ();

	cobs_stream_receiver_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt_if),
		.res       (res_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// ------------------------------------------------------------------
	// Decoder model state (mirror of the block's)
	// ------------------------------------------------------------------
	logic [15:0]       max_len;
	bit                synced;
	logic [16:0]       frame_pos;   // saturating byte count in frame
	logic [7:0]        skip_left;   // countdown of the current code block
	bit                full_code;   // current code is 0xFF: no implied zero
	logic [15:0]       out_count;   // decoded bytes so far
	logic [STAT_W-1:0] tally [NUM_CNT];

	rx_word_t    decoded_words [$];   // results still owed by the block
	int unsigned mismatches;
	int unsigned words_in;
	int unsigned words_out;
	int unsigned payload_items;       // words sent, of any kind
	int unsigned idle_cycles;
	bit          send_burst;

	stim_row_t directed_rows [N_DIRECTED] = '{
		'{EV_DATA,        8'h55, 1'b1, RK_NONE,    ERR_NONE},      // data while unsynced
		'{EV_OTHER,       8'h00, 1'b1, RK_NONE,    ERR_NONE},
		'{EV_UNUSED,      8'hFF, 1'b1, RK_NONE,    ERR_NONE},
		'{EV_BUFFER_FULL, 8'hAA, 1'b1, RK_NONE,    ERR_NONE},
		'{EV_DATA,        8'h00, 1'b1, RK_NONE,    ERR_NONE},      // sync
		'{EV_DATA,        8'h00, 1'b1, RK_DROPPED, ERR_ZERO_CODE}, // zero as code
		'{EV_DATA,        8'h00, 1'b1, RK_NONE,    ERR_NONE},      // resync
		'{EV_DATA,        8'h03, 1'b1, RK_NONE,    ERR_NONE},      // code
		'{EV_DATA,        8'hAA, 1'b0, RK_NONE,    ERR_NONE},
		'{EV_DATA,        8'h00, 1'b1, RK_DROPPED, ERR_SKIP},      // early delimiter
		'{EV_DATA,        8'h00, 1'b1, RK_NONE,    ERR_NONE},
		'{EV_DATA,        8'h01, 1'b1, RK_NONE,    ERR_NONE},
		'{EV_DATA,        8'h02, 1'b0, RK_NONE,    ERR_NONE},      // implied zero
		'{EV_DATA,        8'hFF, 1'b0, RK_NONE,    ERR_NONE},
		'{EV_DATA,        8'h00, 1'b0, RK_NONE,    ERR_NONE},      // frame of 2
		'{EV_DATA,        8'hFF, 1'b1, RK_NONE,    ERR_NONE},      // full code
		'{EV_DATA,        8'h01, 1'b0, RK_NONE,    ERR_NONE},
		'{EV_PARITY,      8'h00, 1'b1, RK_PHYS,    ERR_NONE},      // mid-frame
		'{EV_FRAMING,     8'hFF, 1'b1, RK_PHYS,    ERR_NONE},      // unsynced
		'{EV_OVERFLOW,    8'h00, 1'b1, RK_PHYS,    ERR_NONE},
		'{EV_BREAK,       8'h7F, 1'b1, RK_PHYS,    ERR_NONE},
		'{EV_DATA,        8'h00, 1'b1, RK_NONE,    ERR_NONE},
		'{EV_DATA,        8'h01, 1'b1, RK_NONE,    ERR_NONE},
		'{EV_DATA,        8'h00, 1'b0, RK_NONE,    ERR_NONE}       // empty frame
	};

	// ------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Decoder model
	// ------------------------------------------------------------------
	function automatic void clear_frame();
		frame_pos = '0;
		skip_left = '0;
		full_code = 1'b0;
		out_count = '0;
	endfunction

	function automatic void lose_frame();
		clear_frame();
		synced = 1'b0;
		tally[CNT_DROP] = tally[CNT_DROP] + 1'b1;
	endfunction

	function automatic void model_reset();
		max_len = MAX_FRAME_RESET;
		synced  = 1'b0;
		clear_frame();
		for (int i = 0; i < NUM_CNT; i++)
			tally[i] = '0;
	endfunction

	// one event in, one result word out; updates the model state
	function automatic rx_word_t decode_word(logic [2:0] kind, logic [7:0] b);
		rx_word_t   w;
		bit         emit;
		logic [7:0] val;
		w      = '0;
		w.kind = RK_NONE;
		w.err  = ERR_NONE;
		case (kind)
			EV_PARITY, EV_FRAMING, EV_OVERFLOW, EV_BREAK: begin
				case (kind)
					EV_PARITY:   tally[CNT_PARITY]   = tally[CNT_PARITY] + 1'b1;
					EV_FRAMING:  tally[CNT_FRAMING]  = tally[CNT_FRAMING] + 1'b1;
					EV_OVERFLOW: tally[CNT_OVERFLOW] = tally[CNT_OVERFLOW] + 1'b1;
					default:     tally[CNT_BREAK]    = tally[CNT_BREAK] + 1'b1;
				endcase
				lose_frame();
				w.kind = RK_PHYS;
			end
			EV_BUFFER_FULL: tally[CNT_BUFFER_FULL] = tally[CNT_BUFFER_FULL] + 1'b1;
			EV_DATA: begin
				if (!synced) begin
					if (b == BYTE_ZERO)
						synced = 1'b1;
				end else if (frame_pos == '0) begin
					// first byte of a frame is a code
					if (b == BYTE_ZERO) begin
						lose_frame();
						w.kind = RK_DROPPED;
						w.err  = ERR_ZERO_CODE;
					end else begin
						skip_left = b;
						full_code = (b == CODE_FULL);
						frame_pos = 17'd1;
					end
				end else if (b == BYTE_ZERO) begin
					// delimiter is only legal where the next code is due
					if (skip_left != 8'd1) begin
						lose_frame();
						w.kind = RK_DROPPED;
						w.err  = ERR_SKIP;
					end else begin
						w.kind = RK_DONE;
						w.flen = out_count;
						clear_frame();
					end
				end else begin
					emit      = 1'b1;
					val       = b;
					skip_left = skip_left - 8'd1;
					if (skip_left == 8'd0) begin
						// this byte is the next code; a 0xFF block implies no zero
						emit      = !full_code;
						val       = BYTE_ZERO;
						skip_left = b;
						full_code = (b == CODE_FULL);
					end
					if (emit && out_count >= max_len) begin
						lose_frame();
						w.kind = RK_DROPPED;
						w.err  = ERR_LENGTH;
					end else begin
						if (emit) begin
							w.kind    = RK_BYTE;
							w.dbyte   = val;
							w.idx     = out_count;
							out_count = out_count + 16'd1;
						end
						if (frame_pos != '1)
							frame_pos = frame_pos + 17'd1;
					end
				end
			end
			default: ;  // other / unused kinds are ignored
		endcase
		for (int i = 0; i < NUM_CNT; i++)
			w.tally[i] = tally[i];
		return w;
	endfunction

	// standard COBS encode plus trailing delimiter
	function automatic byte_q_t cobs_pack(byte_q_t payload);
		byte_q_t    enc;
		int         code_at;
		logic [7:0] code;
		enc.push_back(BYTE_ZERO);
		code_at = 0;
		code    = 8'd1;
		foreach (payload[i]) begin
			if (payload[i] == BYTE_ZERO) begin
				enc[code_at] = code;
				code_at      = enc.size();
				enc.push_back(BYTE_ZERO);
				code = 8'd1;
			end else begin
				enc.push_back(payload[i]);
				code = code + 8'd1;
				if (code == CODE_FULL) begin
					enc[code_at] = code;
					code_at      = enc.size();
					enc.push_back(BYTE_ZERO);
					code = 8'd1;
				end
			end
		end
		enc[code_at] = code;
		enc.push_back(BYTE_ZERO);
		return enc;
	endfunction

	// mostly short frames; now and then a long zero-free one for 0xFF blocks
	function automatic byte_q_t make_payload();
		byte_q_t     p;
		int unsigned len;
		int unsigned zero_pct;
		if ($urandom_range(0, 99) < 92) begin
			len      = $urandom_range(0, 24);
			zero_pct = 20;
		end else begin
			len      = $urandom_range(250, 300);
			zero_pct = 0;
		end
		repeat (len) begin
			if ($urandom_range(0, 99) < zero_pct)
				p.push_back(BYTE_ZERO);
			else
				p.push_back(8'($urandom_range(1, 255)));
		end
		return p;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(6, 30);
	endfunction

	// ------------------------------------------------------------------
	// Event sender. Called at a rising edge; returns at the accepting edge
	// with valid still high, so back-to-back words need no extra NBA.
	// ------------------------------------------------------------------
	task automatic put_word(logic [2:0] kind, logic [7:0] data, bit typed = 1'b0,
			result_kind_t tkind = RK_NONE, error_code_t terr = ERR_NONE);
		int unsigned gap;
		rx_word_t    w;
		gap = send_burst ? 0 : pick_gap();
		if (gap > 0) begin
			evt_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_if.valid      <= 1'b1;
		evt_if.event_kind <= kind;
		evt_if.data_byte  <= data;
		do @(posedge clk); while (!evt_if.ready);
		w = decode_word(kind, data);
		if (typed) begin
			w.kind = tkind;
			w.err  = terr;
		end
		decoded_words.push_back(w);
		payload_items++;
		if ($urandom_range(0, 63) == 0)
			send_burst = !send_burst;
	endtask

	task automatic send_bytes(byte_q_t q);
		foreach (q[i])
			put_word(EV_DATA, q[i]);
	endtask

	task automatic line_error();
		put_word(3'($urandom_range(EV_PARITY, EV_BREAK)), 8'($urandom));
	endtask

	// drop valid, wait for every owed result, then let the pipe go quiet
	task automatic settle();
		evt_if.valid <= 1'b0;
		while (decoded_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write; only called with the block idle
	task automatic set_max_len(logic [15:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we  <= 1'b0;
		max_len = v;
	endtask

	// ------------------------------------------------------------------
	// Random traffic: mostly good frames, plus noise, broken frames,
	// line errors and status events.
	// ------------------------------------------------------------------
	task automatic random_traffic(int unsigned quota);
		int unsigned start;
		int unsigned r;
		int unsigned cut;
		byte_q_t     enc;
		start = payload_items;
		while (payload_items - start < quota) begin
			r = $urandom_range(0, 99);
			if (r < 72) begin
				// well-formed frame; resync first if a drop left us unsynced
				if (!synced)
					put_word(EV_DATA, BYTE_ZERO);
				send_bytes(cobs_pack(make_payload()));
			end else if (r < 80) begin
				line_error();
			end else if (r < 88) begin
				repeat ($urandom_range(1, 6)) begin
					if ($urandom_range(0, 99) < 60)
						put_word(EV_DATA, 8'($urandom));
					else
						put_word(3'($urandom_range(1, 7)), 8'($urandom));
				end
			end else if (r < 96) begin
				// broken frame: bad byte, or a line error part way in
				if (!synced)
					put_word(EV_DATA, BYTE_ZERO);
				enc = cobs_pack(make_payload());
				cut = $urandom_range(0, enc.size() - 2);
				case ($urandom_range(0, 2))
					0: begin
						enc[cut] = BYTE_ZERO;
						send_bytes(enc);
					end
					1: begin
						enc[cut] = 8'($urandom_range(1, 255));
						send_bytes(enc);
					end
					default: begin
						for (int i = 0; i < cut; i++)
							put_word(EV_DATA, enc[i]);
						line_error();
					end
				endcase
			end else begin
				case ($urandom_range(0, 2))
					0:       put_word(EV_BUFFER_FULL, 8'($urandom));
					1:       put_word(EV_OTHER, 8'($urandom));
					default: put_word(EV_UNUSED, 8'($urandom));
				endcase
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		logic [15:0] settings [NUM_PHASES];
		evt_if.valid      <= 1'b0;
		evt_if.event_kind <= EV_DATA;
		evt_if.data_byte  <= 8'h00;
		cfg_we            <= 1'b0;
		cfg_wdata         <= 16'h0000;
		arst_n            <= 1'b0;
		mismatches    = 0;
		payload_items = 0;
		send_burst    = 1'b0;
		model_reset();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, at reset setting of max_frame_bytes
		foreach (directed_rows[i])
			put_word(directed_rows[i].kind, directed_rows[i].data, directed_rows[i].typed,
				directed_rows[i].tkind, directed_rows[i].terr);
		settle();

		// extremes first, zero included, then a small random limit and back to reset value
		settings = '{16'hFFFF, 16'h0000, 16'h0001, 16'($urandom_range(2, 40)),
			MAX_FRAME_RESET};
		foreach (settings[p]) begin
			set_max_len(settings[p]);
			random_traffic(RANDOM_WORDS / NUM_PHASES);
			settle();
		end

		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// ------------------------------------------------------------------
	// Result side back-pressure, with stretches of free flow and one long
	// hold mid-run so the pipe fills and the event side stalls.
	// ------------------------------------------------------------------
	initial begin
		int unsigned n;
		bit          hold_done;
		bit          free_run;
		hold_done = 1'b0;
		free_run  = 1'b0;
		res_if.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (!hold_done && words_in >= HOLD_AT) begin
				hold_done = 1'b1;
				res_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if ($urandom_range(0, 15) == 0)
				free_run = !free_run;
			n = free_run ? 0 : pick_gap();
			if (n > 0) begin
				res_if.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// ------------------------------------------------------------------
	// Result checker: each accepted word against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		rx_word_t got;
		rx_word_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			got.kind                  = result_kind_t'(res_if.result_kind);
			got.dbyte                 = res_if.decoded_byte;
			got.idx                   = res_if.byte_index;
			got.flen                  = res_if.frame_length;
			got.err                   = error_code_t'(res_if.error_code);
			got.tally[CNT_DROP]        = res_if.drop_total;
			got.tally[CNT_PARITY]      = res_if.parity_errors;
			got.tally[CNT_FRAMING]     = res_if.framing_errors;
			got.tally[CNT_OVERFLOW]    = res_if.overflow_errors;
			got.tally[CNT_BREAK]       = res_if.break_events;
			got.tally[CNT_BUFFER_FULL] = res_if.buffer_full_events;
			if (decoded_words.size() == 0) begin
				if (mismatches < REPORT_MAX)
					$display("%0t: result word %0d with none outstanding: kind=%0d",
						$realtime, words_out, got.kind);
				mismatches++;
			end else begin
				want = decoded_words.pop_front();
				if (got.kind !== want.kind || got.dbyte !== want.dbyte ||
						got.idx !== want.idx || got.flen !== want.flen ||
						got.err !== want.err || got.tally !== want.tally) begin
					if (mismatches < REPORT_MAX) begin
						$display("%0t: result word %0d mismatch", $realtime, words_out);
						$display("  exp kind=%0d byte=%02h idx=%0d len=%0d err=%0d cnt=%p",
							want.kind, want.dbyte, want.idx, want.flen, want.err, want.tally);
						$display("  got kind=%0d byte=%02h idx=%0d len=%0d err=%0d cnt=%p",
							got.kind, got.dbyte, got.idx, got.flen, got.err, got.tally);
					end
					mismatches++;
				end
			end
			words_out++;
		end
	end

	// ------------------------------------------------------------------
	// Activity count and watchdog: too long with no word moving on
	// either channel ends the run as failed.
	// ------------------------------------------------------------------
	initial begin
		words_in    = 0;
		words_out   = 0;
		idle_cycles = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (evt_if.valid && evt_if.ready)
				words_in++;
			if ((evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

endmodule

// ===== files.f =====
rtl/csr_pkg.sv
rtl/csr_ifs.sv
rtl/csr_decoder.sv
rtl/csr_counters.sv
rtl/cobs_stream_receiver_unit.sv
verif/cobs_stream_receiver_unit_tb.sv
